@@ sv/arqrb_pkg.sv @@
// Package for the ARQ receive reorder buffer: word types, result codes,
// controller states and the command/status structs between the submodules.
// No dependencies.
package arqrb_pkg;

    // Operation codes of an input word.
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_SKIP    = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    // Configuration space.
    localparam int          APB_ADDR_BITS = 3;
    localparam logic        REG_RX_WAIT   = 1'b0;
    localparam logic [15:0] RX_WAIT_RESET = 16'd1800;

    typedef struct packed {
        logic        op;
        logic [7:0]  seq_number;
        logic [15:0] pdu_handle;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_seq;
        logic [15:0] out_handle;
        logic        last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GAP,
        ST_ACK,
        ST_TICK,
        ST_TDRAIN,
        ST_REL_RD,
        ST_REL_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic walk_init;
        logic gap_step;
        logic tick_rd;
        logic pay_rd;
        logic emit_ack;
        logic emit_reject;
        logic emit_release;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic reject;
        logic gap_done;
        logic tick_last;
        logic head_rel;
    } status_t;

endpackage

@@ sv/arqrb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module arqrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/arqrb_cfg.sv @@
// APB-style configuration register file holding the rx-wait tick count.
// Depends on arqrb_pkg.
module arqrb_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [arqrb_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [15:0]                        rx_wait_ticks
);

    logic [15:0] rx_wait_reg;
    logic [15:0] rx_wait_next;
    logic        hit;

    assign hit = (paddr[arqrb_pkg::APB_ADDR_BITS-1:2] == arqrb_pkg::REG_RX_WAIT);

    always_comb
    begin
        rx_wait_next = rx_wait_reg;
        if (psel && penable && pwrite && hit)
        begin
            rx_wait_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wait_reg <= arqrb_pkg::RX_WAIT_RESET;
        end
        else
        begin
            rx_wait_reg <= rx_wait_next;
        end
    end

    assign prdata        = hit ? {16'd0, rx_wait_reg} : 32'd0;
    assign pready        = 1'b1;
    assign rx_wait_ticks = rx_wait_reg;

endmodule

@@ sv/arqrb_ctrl.sv @@
// Controller state machine of the reorder buffer: sequences receive, tick
// and in-order release steps. Depends on arqrb_pkg.
module arqrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  arqrb_pkg::status_t status,
    output arqrb_pkg::cmd_t    cmd,
    output logic               busy
);

    arqrb_pkg::ctrl_state_t state_reg;
    arqrb_pkg::ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arqrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = arqrb_pkg::ST_DISPATCH;
                end
            end
            arqrb_pkg::ST_DISPATCH:
            begin
                if (status.is_tick)
                begin
                    state_next = arqrb_pkg::ST_TICK;
                end
                else if (status.reject)
                begin
                    state_next = arqrb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = arqrb_pkg::ST_GAP;
                end
            end
            arqrb_pkg::ST_GAP:
            begin
                if (status.gap_done)
                begin
                    state_next = arqrb_pkg::ST_ACK;
                end
            end
            arqrb_pkg::ST_ACK:
            begin
                state_next = status.head_rel ? arqrb_pkg::ST_REL_RD : arqrb_pkg::ST_IDLE;
            end
            arqrb_pkg::ST_TICK:
            begin
                if (status.tick_last)
                begin
                    state_next = arqrb_pkg::ST_TDRAIN;
                end
            end
            arqrb_pkg::ST_TDRAIN:
            begin
                state_next = arqrb_pkg::ST_REL_RD;
            end
            arqrb_pkg::ST_REL_RD:
            begin
                state_next = status.head_rel ? arqrb_pkg::ST_REL_OUT : arqrb_pkg::ST_IDLE;
            end
            arqrb_pkg::ST_REL_OUT:
            begin
                state_next = arqrb_pkg::ST_REL_RD;
            end
            default:
            begin
                state_next = arqrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            arqrb_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            arqrb_pkg::ST_DISPATCH:
            begin
                cmd.walk_init   = status.is_tick || !status.reject;
                cmd.emit_reject = !status.is_tick && status.reject;
            end
            arqrb_pkg::ST_GAP:
            begin
                cmd.gap_step = 1'b1;
            end
            arqrb_pkg::ST_ACK:
            begin
                cmd.emit_ack = 1'b1;
            end
            arqrb_pkg::ST_TICK:
            begin
                cmd.tick_rd = 1'b1;
            end
            arqrb_pkg::ST_REL_RD:
            begin
                cmd.pay_rd = status.head_rel;
            end
            arqrb_pkg::ST_REL_OUT:
            begin
                cmd.emit_release = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arqrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != arqrb_pkg::ST_IDLE);

endmodule

@@ sv/arqrb_dp.sv @@
// Datapath of the reorder buffer: circular slot window with flag registers,
// countdown and payload RAMs, walk counters and the result register.
// Depends on arqrb_pkg and arqrb_ram.
module arqrb_dp #(
    parameter int WINDOW      = 16,
    parameter int SEQ_SPACE   = 255,
    parameter int HANDLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  arqrb_pkg::in_word_t item,
    input  logic [15:0]         rx_wait_ticks,
    input  arqrb_pkg::cmd_t     cmd,
    output arqrb_pkg::status_t  status,
    output arqrb_pkg::out_word_t result,
    output logic                result_valid
);

    localparam int IW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW - 1);
    localparam logic [7:0]    LAST_SEQ  = 8'(SEQ_SPACE - 1);

    function automatic logic [IW-1:0] inc_ptr(input logic [IW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    arqrb_pkg::in_word_t  item_reg;
    arqrb_pkg::in_word_t  item_next;
    arqrb_pkg::out_word_t result_reg;
    arqrb_pkg::out_word_t result_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    logic [7:0]        ne_reg, ne_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [WINDOW-1:0] resolved_reg, resolved_next;
    logic [WINDOW-1:0] lost_reg, lost_next;
    logic [WINDOW-1:0] waiting_reg, waiting_next;
    logic [IW-1:0]     walk_ptr_reg, walk_ptr_next;
    logic [CW-1:0]     walk_cnt_reg, walk_cnt_next;
    logic              trd_v_reg, trd_v_next;
    logic [IW-1:0]     trd_p_reg, trd_p_next;

    logic [8:0]    distance;
    logic          out_of_space;
    logic [IW-1:0] head_inc;

    logic          cd_we;
    logic [IW-1:0] cd_waddr;
    logic [15:0]   cd_wdata;
    logic [15:0]   cd_q;
    logic          pay_we;
    logic [HW-1:0] pay_q;

    // Distance from next_expected, taken modulo the sequence space.
    always_comb
    begin
        if (item_reg.seq_number >= ne_reg)
        begin
            distance = {1'b0, item_reg.seq_number} - {1'b0, ne_reg};
        end
        else
        begin
            distance = {1'b0, item_reg.seq_number} + 9'(SEQ_SPACE) - {1'b0, ne_reg};
        end
    end

    assign out_of_space = ({1'b0, item_reg.seq_number} >= 9'(SEQ_SPACE));
    assign head_inc     = inc_ptr(head_reg);

    assign status.is_tick   = (item_reg.op == arqrb_pkg::OP_TICK);
    assign status.reject    = out_of_space || (distance >= 9'(WINDOW));
    assign status.gap_done  = (walk_cnt_reg == '0);
    assign status.tick_last = (walk_ptr_reg == LAST_SLOT);
    assign status.head_rel  = resolved_reg[head_reg];

    always_comb
    begin
        item_next         = item_reg;
        ne_next           = ne_reg;
        head_next         = head_reg;
        resolved_next     = resolved_reg;
        lost_next         = lost_reg;
        waiting_next      = waiting_reg;
        walk_ptr_next     = walk_ptr_reg;
        walk_cnt_next     = walk_cnt_reg;
        trd_v_next        = 1'b0;
        trd_p_next        = trd_p_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        cd_we             = 1'b0;
        cd_waddr          = walk_ptr_reg;
        cd_wdata          = rx_wait_ticks;
        pay_we            = 1'b0;

        if (cmd.load)
        begin
            item_next = item;
        end

        if (cmd.walk_init)
        begin
            if (item_reg.op == arqrb_pkg::OP_TICK)
            begin
                walk_ptr_next = '0;
            end
            else
            begin
                walk_ptr_next = head_reg;
                walk_cnt_next = CW'(distance);
            end
        end

        // One gap slot per cycle, then the received slot itself.
        if (cmd.gap_step)
        begin
            if (walk_cnt_reg != '0)
            begin
                if (!resolved_reg[walk_ptr_reg] && !waiting_reg[walk_ptr_reg])
                begin
                    waiting_next[walk_ptr_reg] = 1'b1;
                    cd_we = 1'b1;
                end
                walk_ptr_next = inc_ptr(walk_ptr_reg);
                walk_cnt_next = walk_cnt_reg - 1'b1;
            end
            else
            begin
                resolved_next[walk_ptr_reg] = 1'b1;
                lost_next[walk_ptr_reg]     = 1'b0;
                waiting_next[walk_ptr_reg]  = 1'b0;
                pay_we = 1'b1;
            end
        end

        if (cmd.tick_rd)
        begin
            trd_v_next    = 1'b1;
            trd_p_next    = walk_ptr_reg;
            walk_ptr_next = inc_ptr(walk_ptr_reg);
        end

        // Second stage of the tick walk: countdown data is back from the RAM.
        if (trd_v_reg && waiting_reg[trd_p_reg])
        begin
            if (cd_q <= 16'd1)
            begin
                waiting_next[trd_p_reg]  = 1'b0;
                resolved_next[trd_p_reg] = 1'b1;
                lost_next[trd_p_reg]     = 1'b1;
            end
            else
            begin
                cd_we    = 1'b1;
                cd_waddr = trd_p_reg;
                cd_wdata = cd_q - 16'd1;
            end
        end

        if (cmd.emit_reject)
        begin
            result_valid_next      = 1'b1;
            result_next.kind       = arqrb_pkg::KIND_REJECT;
            result_next.out_seq    = item_reg.seq_number;
            result_next.out_handle = '0;
            result_next.last       = 1'b1;
        end

        if (cmd.emit_ack)
        begin
            result_valid_next      = 1'b1;
            result_next.kind       = arqrb_pkg::KIND_ACK;
            result_next.out_seq    = item_reg.seq_number;
            result_next.out_handle = '0;
            result_next.last       = !resolved_reg[head_reg];
        end

        if (cmd.emit_release)
        begin
            result_valid_next   = 1'b1;
            result_next.out_seq = ne_reg;
            result_next.last    = !resolved_reg[head_inc];
            if (lost_reg[head_reg])
            begin
                result_next.kind       = arqrb_pkg::KIND_SKIP;
                result_next.out_handle = '0;
            end
            else
            begin
                result_next.kind       = arqrb_pkg::KIND_DELIVER;
                result_next.out_handle = 16'(pay_q);
            end
            resolved_next[head_reg] = 1'b0;
            lost_next[head_reg]     = 1'b0;
            waiting_next[head_reg]  = 1'b0;
            head_next = head_inc;
            ne_next   = (ne_reg == LAST_SEQ) ? 8'd0 : ne_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg           <= '0;
            head_reg         <= '0;
            resolved_reg     <= '0;
            lost_reg         <= '0;
            waiting_reg      <= '0;
            walk_ptr_reg     <= '0;
            walk_cnt_reg     <= '0;
            trd_v_reg        <= 1'b0;
            trd_p_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ne_reg           <= ne_next;
            head_reg         <= head_next;
            resolved_reg     <= resolved_next;
            lost_reg         <= lost_next;
            waiting_reg      <= waiting_next;
            walk_ptr_reg     <= walk_ptr_next;
            walk_cnt_reg     <= walk_cnt_next;
            trd_v_reg        <= trd_v_next;
            trd_p_reg        <= trd_p_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    arqrb_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW)
    ) u_countdown_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (cd_waddr),
        .wdata (cd_wdata),
        .re    (cmd.tick_rd),
        .raddr (walk_ptr_reg),
        .rdata (cd_q)
    );

    arqrb_ram #(
        .WIDTH (HW),
        .DEPTH (WINDOW)
    ) u_payload_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (walk_ptr_reg),
        .wdata (item_reg.pdu_handle[HW-1:0]),
        .re    (cmd.pay_rd),
        .raddr (head_reg),
        .rdata (pay_q)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

@@ sv/arq_receive_reorder_buffer_unit.sv @@
// Top level of the selective-repeat ARQ receive reorder buffer.
// Depends on arqrb_pkg, arqrb_cfg, arqrb_ctrl and arqrb_dp (and arqrb_ram).
//
//   Channel   Handshake                        Word
//   --------  -------------------------------  ------------------------------
//   input     start and not busy               item   (op, seq_number, handle)
//   result    result_valid, one cycle, no hold result (kind, seq, handle, last)
//   config    psel & penable & pwrite, pready  rx_wait_ticks at byte address 0
//
// A receive keeps busy high while it walks one slot per cycle from the next expected
// number to its own, a tick while it walks the whole window over the countdown RAM;
// every released slot then adds a registered payload read and its result word.
// Results are registered and appear in the cycle after the state that forms them.
// Reset clears the window flags, next expected number and controller at once.
// The result side cannot stall; busy stays high until the last result is formed.
module arq_receive_reorder_buffer_unit #(
    parameter int WINDOW      = 16,
    parameter int SEQ_SPACE   = 255,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  arqrb_pkg::in_word_t                 item,
    output logic                                result_valid,
    output arqrb_pkg::out_word_t                result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [arqrb_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    arqrb_pkg::cmd_t    cmd;
    arqrb_pkg::status_t status;
    logic [15:0]        rx_wait_ticks;

    arqrb_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .rx_wait_ticks (rx_wait_ticks)
    );

    arqrb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    arqrb_dp #(
        .WINDOW      (WINDOW),
        .SEQ_SPACE   (SEQ_SPACE),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .rx_wait_ticks (rx_wait_ticks),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .result_valid  (result_valid)
    );

`ifndef NO_ASSERTIONS
    // An accepted word always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    // Nothing follows the final result of a word in the next cycle.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
        else $error("result directly after a final result");

    // A rejected word causes exactly one result.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == arqrb_pkg::KIND_REJECT) |-> result.last)
        else $error("reject result not marked final");

    // Results are only formed while a word is in work.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a word in work");
`endif

endmodule

@@ sim/arqrb_result_checker.sv @@
// Result checker for the ARQ receive reorder buffer: watches the item, result and APB
// channels, predicts every result word and compares it against the block's output.
// Depends on arqrb_pkg.
module arqrb_result_checker #(
    parameter int WINDOW      = 16,
    parameter int SEQ_SPACE   = 255,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  arqrb_pkg::in_word_t                 item,
    input  logic                                result_valid,
    input  arqrb_pkg::out_word_t                result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [arqrb_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                         pwdata,
    input  logic [31:0]                         prdata,
    input  logic                                pready,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  results_checked,
    output int                                  skips_seen,
    output int                                  rejects_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = arqrb_pkg::APB_ADDR_BITS;
    localparam logic [AW-1:0] RX_WAIT_ADDR = AW'({arqrb_pkg::REG_RX_WAIT, 2'b00});
    localparam logic [15:0] HANDLE_MASK =
        (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HANDLE_BITS) - 1);

    // Shadow of the receive window; slot i holds sequence number head_seq + i.
    logic [15:0]       wait_ticks;
    logic [7:0]        head_seq;
    logic [WINDOW-1:0] occupied;
    logic [WINDOW-1:0] settled;
    logic [WINDOW-1:0] dropped;
    logic [WINDOW-1:0] counting;
    logic [15:0]       timer [WINDOW];
    logic [15:0]       stash [WINDOW];

    arqrb_pkg::out_word_t outcome_q[$];
    int                   failures;
    int                   checked;
    int                   skips;
    int                   rejects;

    function automatic arqrb_pkg::out_word_t make_outcome(logic [1:0] kind,
                                                          logic [7:0] seq,
                                                          logic [15:0] handle);
        arqrb_pkg::out_word_t w;
        w.kind       = kind;
        w.out_seq    = seq;
        w.out_handle = handle;
        w.last       = 1'b0;
        return w;
    endfunction

    // Applies one accepted item to the shadow window and queues the words it causes.
    task automatic apply_arq_word(input arqrb_pkg::in_word_t w);
        arqrb_pkg::out_word_t batch[$];
        arqrb_pkg::out_word_t r;
        int                   span;
        bit                   refused;
        refused = 1'b0;
        span    = 0;
        if (w.op == arqrb_pkg::OP_RECEIVE)
        begin
            if (int'(w.seq_number) >= SEQ_SPACE)
                refused = 1'b1;
            else
            begin
                span    = (int'(w.seq_number) + SEQ_SPACE - int'(head_seq)) % SEQ_SPACE;
                refused = (span >= WINDOW);
            end
            if (refused)
                batch.push_back(make_outcome(arqrb_pkg::KIND_REJECT, w.seq_number, '0));
            else
            begin
                batch.push_back(make_outcome(arqrb_pkg::KIND_ACK, w.seq_number, '0));
                occupied[span] = 1'b1;
                settled[span]  = 1'b1;
                dropped[span]  = 1'b0;
                counting[span] = 1'b0;
                stash[span]    = w.pdu_handle & HANDLE_MASK;
                // Every earlier slot not yet received or lost starts its wait, unless it already runs.
                for (int i = 0; i < span; i++)
                begin
                    if (!occupied[i])
                    begin
                        occupied[i] = 1'b1;
                        settled[i]  = 1'b0;
                        dropped[i]  = 1'b0;
                        stash[i]    = '0;
                        counting[i] = 1'b1;
                        timer[i]    = wait_ticks;
                    end
                    else if (!settled[i] && !counting[i])
                    begin
                        counting[i] = 1'b1;
                        timer[i]    = wait_ticks;
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                if (counting[i])
                begin
                    if (timer[i] <= 16'd1)
                    begin
                        timer[i]    = '0;
                        counting[i] = 1'b0;
                        settled[i]  = 1'b1;
                        dropped[i]  = 1'b1;
                    end
                    else
                        timer[i] = timer[i] - 16'd1;
                end
            end
        end

        if (!refused)
        begin
            while (occupied[0] && settled[0])
            begin
                if (dropped[0])
                    batch.push_back(make_outcome(arqrb_pkg::KIND_SKIP, head_seq, '0));
                else
                    batch.push_back(make_outcome(arqrb_pkg::KIND_DELIVER, head_seq,
                                                 stash[0]));
                for (int i = 0; i < WINDOW - 1; i++)
                begin
                    timer[i] = timer[i + 1];
                    stash[i] = stash[i + 1];
                end
                timer[WINDOW - 1] = '0;
                stash[WINDOW - 1] = '0;
                occupied = occupied >> 1;
                settled  = settled >> 1;
                dropped  = dropped >> 1;
                counting = counting >> 1;
                head_seq = (int'(head_seq) + 1 >= SEQ_SPACE) ? 8'd0 : head_seq + 8'd1;
            end
        end

        foreach (batch[k])
        begin
            r      = batch[k];
            r.last = (k == batch.size() - 1);
            outcome_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        arqrb_pkg::out_word_t want;
        if (!rst_n)
        begin
            wait_ticks = arqrb_pkg::RX_WAIT_RESET;
            head_seq   = '0;
            occupied   = '0;
            settled    = '0;
            dropped    = '0;
            counting   = '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                timer[i] = '0;
                stash[i] = '0;
            end
            outcome_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (outcome_q.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result word with none awaited:", $realtime,
                                 " kind %0d seq %0d handle %h last %b",
                                 result.kind, result.out_seq, result.out_handle,
                                 result.last);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    checked++;
                    if (want.kind == arqrb_pkg::KIND_SKIP)
                        skips++;
                    if (want.kind == arqrb_pkg::KIND_REJECT)
                        rejects++;
                    if (result.kind != want.kind || result.out_seq != want.out_seq ||
                        result.out_handle != want.out_handle || result.last != want.last)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: mismatch: expected", $realtime,
                                     " kind %0d seq %0d handle %h last %b,",
                                     want.kind, want.out_seq, want.out_handle, want.last,
                                     " got kind %0d seq %0d handle %h last %b",
                                     result.kind, result.out_seq, result.out_handle,
                                     result.last);
                    end
                end
            end

            if (start && !busy)
                apply_arq_word(item);

            if (psel && penable && pready && paddr == RX_WAIT_ADDR)
            begin
                if (pwrite)
                    wait_ticks = pwdata[15:0];
                else if (prdata != {16'h0000, wait_ticks})
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: rx_wait_ticks read back %h, expected %h",
                                 $realtime, prdata, {16'h0000, wait_ticks});
                end
            end
        end
        fail_count      <= failures;
        pending         <= outcome_q.size();
        results_checked <= checked;
        skips_seen      <= skips;
        rejects_seen    <= rejects;
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the ARQ receive reorder buffer: clock, reset, item and APB stimulus
// and the final verdict. Depends on arqrb_pkg, arq_receive_reorder_buffer_unit and
// arqrb_result_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW       = 16;
    localparam int SEQ_SPACE    = 255;
    localparam int HANDLE_BITS  = 16;
    localparam int DRAIN_CYCLES = 4 * WINDOW + 16;
    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASES       = 8;
    localparam int AW           = arqrb_pkg::APB_ADDR_BITS;
    localparam logic [AW-1:0] RX_WAIT_ADDR = AW'({arqrb_pkg::REG_RX_WAIT, 2'b00});

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    arqrb_pkg::in_word_t  item;
    logic                 result_valid;
    arqrb_pkg::out_word_t result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AW-1:0]        paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int          fail_count;
    int          pending;
    int          results_checked;
    int          skips_seen;
    int          rejects_seen;
    int          cycle_count = 0;
    int          words_sent;
    logic [7:0]  head_guess;

    arq_receive_reorder_buffer_unit #(
        .WINDOW      (WINDOW),
        .SEQ_SPACE   (SEQ_SPACE),
        .HANDLE_BITS (HANDLE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    arqrb_result_checker #(
        .WINDOW      (WINDOW),
        .SEQ_SPACE   (SEQ_SPACE),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .result_valid    (result_valid),
        .result          (result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .skips_seen      (skips_seen),
        .rejects_seen    (rejects_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles with %0d result words outstanding",
                     cycle_count, pending);
            $display("arq_receive_reorder_buffer_unit verification failed");
            $finish;
        end
    end

    // Rough idea of the next expected number, so that most receives land in the window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_guess <= '0;
        else if (result_valid && (result.kind == arqrb_pkg::KIND_DELIVER ||
                                  result.kind == arqrb_pkg::KIND_SKIP))
            head_guess <= (int'(result.out_seq) + 1 >= SEQ_SPACE) ? 8'd0 :
                          result.out_seq + 8'd1;
    end

    function automatic arqrb_pkg::in_word_t make_word(logic op, logic [7:0] seq,
                                                      logic [15:0] handle);
        arqrb_pkg::in_word_t w;
        w.op         = op;
        w.seq_number = seq;
        w.pdu_handle = handle;
        return w;
    endfunction

    function automatic arqrb_pkg::in_word_t random_word();
        int         pick;
        logic [7:0] seq;
        pick = $urandom_range(99);
        if (pick < 22)
            return make_word(arqrb_pkg::OP_TICK, 8'($urandom_range(255)), 16'($urandom));
        if (pick < 70)
            seq = 8'((int'(head_guess) + $urandom_range(3)) % SEQ_SPACE);
        else if (pick < 90)
            seq = 8'((int'(head_guess) + $urandom_range(WINDOW - 1)) % SEQ_SPACE);
        else if (pick < 97)
            seq = 8'((int'(head_guess) + $urandom_range(SEQ_SPACE - 1, WINDOW)) % SEQ_SPACE);
        else
            seq = 8'hFF;
        return make_word(arqrb_pkg::OP_RECEIVE, seq, 16'($urandom));
    endfunction

    // Holds start high until the word is taken; start stays high for a following word.
    task automatic send_word(input arqrb_pkg::in_word_t w);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Stops sending and waits until every awaited word has come and the block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_rx_wait(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RX_WAIT_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Read the register straight back.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                send_word(random_word());
                sent++;
            end
            if (sent < count && $urandom_range(2) != 0)
            begin
                start <= 1'b0;
                gap = $urandom_range(1, 40);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        logic [15:0] wait_setting;
        int          directed;
        words_sent  = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset wait setting: in-order word, number outside the space, past and beyond
        // the window, an idle tick, then a gap that keeps waiting.
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd0, 16'hFFFF));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd255, 16'h0000));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd0, 16'h1234));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd17, 16'h0000));
        send_word(make_word(arqrb_pkg::OP_TICK, 8'd0, 16'h0000));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd2, 16'h00FF));
        settle();

        // Short wait: a duplicate, a gap lost behind an older one, then the lost number
        // arriving late and the head filling everything in.
        program_rx_wait(16'd1);
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd4, 16'hA5A5));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd4, 16'h5A5A));
        send_word(make_word(arqrb_pkg::OP_TICK, 8'hFF, 16'hFFFF));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd3, 16'h0F0F));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd1, 16'hF0F0));
        settle();

        // Zero wait: every gap in front of a word at the window's far end expires on the first tick.
        program_rx_wait(16'd0);
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd20, 16'hFFFF));
        send_word(make_word(arqrb_pkg::OP_TICK, 8'd0, 16'h0000));
        send_word(make_word(arqrb_pkg::OP_TICK, 8'd0, 16'h0000));
        settle();

        program_rx_wait(16'hFFFF);
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd22, 16'h0001));
        send_word(make_word(arqrb_pkg::OP_TICK, 8'd0, 16'h0000));
        send_word(make_word(arqrb_pkg::OP_RECEIVE, 8'd21, 16'h8000));
        settle();
        directed = words_sent;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: wait_setting = 16'd2;
                1: wait_setting = 16'd0;
                2: wait_setting = 16'hFFFF;
                3: wait_setting = 16'd1;
                5: wait_setting = 16'd6;
                default: wait_setting = 16'($urandom_range(1, 12));
            endcase
            program_rx_wait(wait_setting);
            run_phase(RANDOM_ITEMS / PHASES);
            settle();
        end

        $display("%0d items sent (%0d directed), %0d result words checked,",
                 words_sent, directed, results_checked,
                 " %0d skips, %0d rejects", skips_seen, rejects_seen);
        $display("rx_wait_ticks ran at reset value, 0, 1, 65535 and small values over %0d phases",
                 PHASES);
        if (fail_count == 0)
            $display("arq_receive_reorder_buffer_unit verification clean");
        else
            $display("arq_receive_reorder_buffer_unit verification failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/arqrb_pkg.sv
sv/arqrb_ram.sv
sv/arqrb_cfg.sv
sv/arqrb_ctrl.sv
sv/arqrb_dp.sv
sv/arq_receive_reorder_buffer_unit.sv
sim/arqrb_result_checker.sv
sim/tb_top.sv
